// ===== rtl/core/pps_pkg.sv =====
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package pps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int SLOT_W    = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int TIME_W    = 32;
  localparam int FIELD_W   = 16;
  localparam int PRIO_W    = 8;

  // command codes of an input transaction
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // result kind codes
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_RAN  = 2'd1;
  localparam logic [1:0] KIND_IDLE = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         slot;
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
    logic [PRIO_W-1:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [3:0]        ran_slot;
    logic              finished;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
  } out_item_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] res;
    logic              borrow;
  } alu_rsp_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  addr;
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } load_wr_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  addr;
    logic [FIELD_W-1:0] data;
  } rem_wr_t;

  typedef struct packed {
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
    logic [FIELD_W-1:0] rem;
    logic [PRIO_W-1:0]  prio;
  } slot_rd_t;

endpackage

`default_nettype wire

// ===== rtl/core/pps_if.sv =====
// Valid/ready channel interfaces: input, result and configuration write.
// Depends on pps_pkg for the payload types.
`default_nettype none

interface pps_in_if;
  logic             valid;
  logic             ready;
  pps_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pps_out_if;
  logic               valid;
  logic               ready;
  pps_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pps_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pps_alu.sv =====
// Shared 32-bit add/subtract unit used by the scan and arithmetic steps of the sequencer.
// Depends on pps_pkg.
`default_nettype none

module pps_alu (
  input  var pps_pkg::alu_req_t req,
  output var pps_pkg::alu_rsp_t rsp
);

  logic [pps_pkg::TIME_W:0] sum;
  logic [pps_pkg::TIME_W-1:0] b_eff;
  logic                       is_sub;

  assign is_sub = (req.op == pps_pkg::ALU_SUB);
  assign b_eff  = is_sub ? ~req.b : req.b;
  assign sum    = {1'b0, req.a} + {1'b0, b_eff} + {{pps_pkg::TIME_W{1'b0}}, is_sub};

  assign rsp.res    = sum[pps_pkg::TIME_W-1:0];
  // borrow: a < b on subtract
  assign rsp.borrow = is_sub & ~sum[pps_pkg::TIME_W];

endmodule

`default_nettype wire

// ===== rtl/core/pps_slot_file.sv =====
// Per-slot process stores: arrival, burst, priority and remaining work.
// Depends on pps_pkg. One read address per cycle; remaining work resets to zero.
`default_nettype none

module pps_slot_file (
  input  var logic                        clk,
  input  var logic                        rst_n,
  input  var pps_pkg::load_wr_t           load_wr,
  input  var pps_pkg::rem_wr_t            rem_wr,
  input  var logic [pps_pkg::SLOT_W-1:0]  rd_addr,
  output var pps_pkg::slot_rd_t           rd_data
);

  logic [pps_pkg::FIELD_W-1:0] arrival_r [pps_pkg::MAX_PROCS];
  logic [pps_pkg::FIELD_W-1:0] burst_r   [pps_pkg::MAX_PROCS];
  logic [pps_pkg::PRIO_W-1:0]  prio_r    [pps_pkg::MAX_PROCS];
  logic [pps_pkg::FIELD_W-1:0] rem_r     [pps_pkg::MAX_PROCS];

  // payload stores, no reset (an unloaded slot has no remaining work, so its payload is never used)
  always_ff @(posedge clk) begin
    if (load_wr.en) begin
      arrival_r[load_wr.addr] <= load_wr.arrival;
      burst_r[load_wr.addr]   <= load_wr.burst;
      prio_r[load_wr.addr]    <= load_wr.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pps_pkg::MAX_PROCS; i++) begin
        rem_r[i] <= '0;
      end
    end else if (load_wr.en) begin
      rem_r[load_wr.addr] <= load_wr.burst;
    end else if (rem_wr.en) begin
      rem_r[rem_wr.addr] <= rem_wr.data;
    end
  end

  assign rd_data.arrival = arrival_r[rd_addr];
  assign rd_data.burst   = burst_r[rd_addr];
  assign rd_data.prio    = prio_r[rd_addr];
  assign rd_data.rem     = rem_r[rd_addr];

endmodule

`default_nettype wire

// ===== rtl/core/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler: sequencer around a shared add/subtract unit.
// A load goes straight to write-back; a tick scans the active slots (if any),
// then runs INC, DEC, TAT and WT as needed; a stalled result waits in WB.
// Throughput: one transaction at a time; in ready only while the sequencer idles.
// The slot scan (one slot per cycle through the shared unit) sets the tick cost.
// Reset (rst_n low, synchronous): clears tick clock, finished count, process
// count, remaining work and the result valid flag.
`default_nettype none

module preemptive_priority_scheduler (
  input  var logic   clk,
  input  var logic   rst_n,
  pps_in_if.sink     in_chan,
  pps_out_if.source  out_chan,
  pps_cfg_if.sink    cfg_chan
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,   // walk the active slots, one per cycle
    ST_INC,    // completion candidate = tick + 1; tick clock advances
    ST_DEC,    // remaining work of the chosen slot minus one
    ST_TAT,    // turnaround = completion - arrival
    ST_WT,     // waiting = turnaround - burst
    ST_WB      // hand result to the output register
  } state_t;

  state_t                        state_r;
  logic [pps_pkg::CNT_W-1:0]     idx_r;
  logic [pps_pkg::SLOT_W-1:0]    best_r;
  logic [pps_pkg::PRIO_W-1:0]    best_prio_r;
  logic                          found_r;
  logic                          fin_r;
  logic [1:0]                    kind_r;
  logic [pps_pkg::TIME_W-1:0]    tick_r;
  logic [pps_pkg::TIME_W-1:0]    ct_r;
  logic [pps_pkg::TIME_W-1:0]    tat_r;
  logic [pps_pkg::TIME_W-1:0]    wt_r;
  logic [pps_pkg::CNT_W-1:0]     fcount_r;
  logic [4:0]                    pcount_r;
  pps_pkg::out_item_t            out_r;
  logic                          out_valid_r;

  logic [pps_pkg::CNT_W-1:0]     n_active;
  logic [pps_pkg::CNT_W-1:0]     idx_inc;
  logic                          in_fire;
  logic                          out_free;
  logic                          eligible;
  pps_pkg::alu_req_t             alu_req;
  pps_pkg::alu_rsp_t             alu_rsp;
  pps_pkg::load_wr_t             load_wr;
  pps_pkg::rem_wr_t              rem_wr;
  logic [pps_pkg::SLOT_W-1:0]    rd_addr;
  pps_pkg::slot_rd_t             rd_data;
  pps_pkg::out_item_t            result;

  // process count saturates at the number of physical slots
  assign n_active = (32'(pcount_r) > pps_pkg::MAX_PROCS) ?
                    pps_pkg::CNT_W'(pps_pkg::MAX_PROCS) : pps_pkg::CNT_W'(pcount_r);
  assign idx_inc  = idx_r + pps_pkg::CNT_W'(1);

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_free       = !out_valid_r || out_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  // load transaction writes the slot stores directly; slots past the file drop
  assign load_wr.en      = in_fire && (in_chan.data.cmd == pps_pkg::CMD_LOAD) &&
                           (32'(in_chan.data.slot) < pps_pkg::MAX_PROCS);
  assign load_wr.addr    = pps_pkg::SLOT_W'(in_chan.data.slot);
  assign load_wr.arrival = in_chan.data.arrival;
  assign load_wr.burst   = in_chan.data.burst;
  assign load_wr.prio    = in_chan.data.priority_req;

  assign rd_addr = (state_r == ST_SCAN) ? idx_r[pps_pkg::SLOT_W-1:0] : best_r;

  assign rem_wr.en   = (state_r == ST_DEC);
  assign rem_wr.addr = best_r;
  assign rem_wr.data = alu_rsp.res[pps_pkg::FIELD_W-1:0];

  pps_slot_file u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .load_wr (load_wr),
    .rem_wr  (rem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared unit operand steering, one operation per sequencer step
  always_comb begin
    alu_req.op = pps_pkg::ALU_SUB;
    alu_req.a  = tick_r;
    alu_req.b  = {{(pps_pkg::TIME_W-pps_pkg::FIELD_W){1'b0}}, rd_data.arrival};
    unique case (state_r)
      ST_INC: begin
        alu_req.op = pps_pkg::ALU_ADD;
        alu_req.b  = pps_pkg::TIME_W'(1);
      end
      ST_DEC: begin
        alu_req.a = {{(pps_pkg::TIME_W-pps_pkg::FIELD_W){1'b0}}, rd_data.rem};
        alu_req.b = pps_pkg::TIME_W'(1);
      end
      ST_TAT: begin
        alu_req.a = ct_r;
      end
      ST_WT: begin
        alu_req.a = tat_r;
        alu_req.b = {{(pps_pkg::TIME_W-pps_pkg::FIELD_W){1'b0}}, rd_data.burst};
      end
      default: begin
      end
    endcase
  end

  pps_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // scan: arrived (tick >= arrival), work left, strictly better priority;
  // strict compare keeps the lowest slot on ties
  assign eligible = (rd_data.rem != '0) && !alu_rsp.borrow &&
                    (!found_r || (rd_data.prio < best_prio_r));

  always_comb begin
    result                 = '0;
    result.kind            = kind_r;
    result.all_done        = (fcount_r >= n_active);
    if (kind_r == pps_pkg::KIND_RAN) begin
      result.ran_slot = 4'(best_r);
      result.finished = fin_r;
      if (fin_r) begin
        result.completion_time = ct_r;
        result.turnaround      = tat_r;
        result.waiting         = wt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      best_r      <= '0;
      best_prio_r <= '0;
      found_r     <= 1'b0;
      fin_r       <= 1'b0;
      kind_r      <= pps_pkg::KIND_LOAD;
      tick_r      <= '0;
      fcount_r    <= '0;
      pcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        pcount_r <= cfg_chan.data;
      end
      // drain the result register; ST_WB handles its own reload
      if (out_valid_r && out_chan.ready && (state_r != ST_WB)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            idx_r   <= '0;
            best_r  <= '0;
            found_r <= 1'b0;
            fin_r   <= 1'b0;
            if (in_chan.data.cmd == pps_pkg::CMD_LOAD) begin
              tick_r   <= '0;
              fcount_r <= '0;
              kind_r   <= pps_pkg::KIND_LOAD;
              state_r  <= ST_WB;
            end else if (n_active == '0) begin
              state_r <= ST_INC;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (eligible) begin
            best_r      <= idx_r[pps_pkg::SLOT_W-1:0];
            best_prio_r <= rd_data.prio;
            found_r     <= 1'b1;
          end
          idx_r <= idx_inc;
          if (idx_inc == n_active) begin
            state_r <= ST_INC;
          end
        end
        ST_INC: begin
          ct_r   <= alu_rsp.res;
          tick_r <= alu_rsp.res;
          if (found_r) begin
            kind_r  <= pps_pkg::KIND_RAN;
            state_r <= ST_DEC;
          end else begin
            kind_r  <= pps_pkg::KIND_IDLE;
            state_r <= ST_WB;
          end
        end
        ST_DEC: begin
          if (alu_rsp.res[pps_pkg::FIELD_W-1:0] == '0) begin
            fin_r    <= 1'b1;
            fcount_r <= fcount_r + pps_pkg::CNT_W'(1);
            state_r  <= ST_TAT;
          end else begin
            state_r <= ST_WB;
          end
        end
        ST_TAT: begin
          tat_r   <= alu_rsp.res;
          state_r <= ST_WT;
        end
        ST_WT: begin
          wt_r    <= alu_rsp.res;
          state_r <= ST_WB;
        end
        ST_WB: begin
          // wait for a free output register
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload register, no reset needed
  always_ff @(posedge clk) begin
    if (state_r == ST_WB && out_free) begin
      out_r <= result;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pps_checker.sv =====
// Port-level checker for the preemptive priority scheduler, bound to the top.
// Depends on pps_pkg and preemptive_priority_scheduler.
`default_nettype none

module pps_checker (
  input var logic               clk,
  input var logic               rst_n,
  input var logic               in_valid,
  input var logic               in_ready,
  input var logic               out_valid,
  input var logic               out_ready,
  input var pps_pkg::out_item_t out_data
);

  // a stalled result holds its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the sequencer is busy right after it takes a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

  // completion only reported when a process ran
  a_fin_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.finished |-> out_data.kind == pps_pkg::KIND_RAN)
    else $error("finished without a running slot");

  // times are zero unless a process completed
  a_times_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.finished |->
      out_data.completion_time == '0 && out_data.turnaround == '0 &&
      out_data.waiting == '0)
    else $error("times reported without completion");

  // slot number only on a running tick
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != pps_pkg::KIND_RAN |-> out_data.ran_slot == '0)
    else $error("slot reported on a load or idle tick");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the preemptive priority scheduler.
// Depends on pps_pkg, the channel interfaces in pps_if.sv and the scheduler RTL.

module tb_top;

  // Watchdog: cycles in a row with no transaction on any channel.
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 600;
  localparam int TAIL_CYCLES = 40;

  // Shadow of the scheduler: slot tables, tick clock, finished count.
  // Every accepted request yields exactly one report, queued in order.
  class sched_tracker;
    bit [4:0]    proc_count;
    bit [15:0]   arrival_tab [pps_pkg::MAX_PROCS];
    bit [15:0]   burst_tab   [pps_pkg::MAX_PROCS];
    bit [15:0]   work_left   [pps_pkg::MAX_PROCS];
    bit [7:0]    prio_tab    [pps_pkg::MAX_PROCS];
    bit [31:0]   tick_clock;
    int unsigned done_count;
    pps_pkg::out_item_t pending_reports [$];
    int          errors;
    int          n_loads;
    int          n_runs;
    int          n_idle;
    int          n_done;

    function new();
      proc_count = '0;
      tick_clock = '0;
      done_count = 0;
      foreach (work_left[i]) work_left[i] = '0;
      errors  = 0;
      n_loads = 0;
      n_runs  = 0;
      n_idle  = 0;
      n_done  = 0;
    endfunction

    function void set_count(bit [4:0] value);
      proc_count = value;
    endfunction

    function void note_request(pps_pkg::in_item_t req);
      pps_pkg::out_item_t rpt;
      int unsigned active;
      int          best;
      bit          found;
      rpt    = '0;
      active = (proc_count > pps_pkg::MAX_PROCS) ? pps_pkg::MAX_PROCS : proc_count;
      if (req.cmd == pps_pkg::CMD_LOAD) begin
        if (req.slot < pps_pkg::MAX_PROCS) begin
          arrival_tab[req.slot] = req.arrival;
          burst_tab[req.slot]   = req.burst;
          work_left[req.slot]   = req.burst;
          prio_tab[req.slot]    = req.priority_req;
        end
        tick_clock = '0;
        done_count = 0;
        rpt.kind   = pps_pkg::KIND_LOAD;
        n_loads++;
      end else begin
        found = 1'b0;
        best  = 0;
        // lowest prio value among ready slots, first slot wins a tie
        for (int i = 0; i < active; i++) begin
          if (work_left[i] != 0 && 32'(arrival_tab[i]) <= tick_clock &&
              (!found || prio_tab[i] < prio_tab[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (found) begin
          rpt.kind     = pps_pkg::KIND_RAN;
          rpt.ran_slot = 4'(best);
          work_left[best] = work_left[best] - 16'd1;
          n_runs++;
          if (work_left[best] == 0) begin
            rpt.finished        = 1'b1;
            rpt.completion_time = tick_clock + 32'd1;
            rpt.turnaround      = rpt.completion_time - 32'(arrival_tab[best]);
            rpt.waiting         = rpt.turnaround - 32'(burst_tab[best]);
            done_count++;
            n_done++;
          end
        end else begin
          rpt.kind = pps_pkg::KIND_IDLE;
          n_idle++;
        end
        tick_clock = tick_clock + 32'd1;
      end
      rpt.all_done = (done_count >= active);
      pending_reports.push_back(rpt);
    endfunction

    function string show(pps_pkg::out_item_t r);
      return $sformatf("kind=%0d slot=%0d fin=%0b ct=%0d tat=%0d wt=%0d done=%0b",
                       r.kind, r.ran_slot, r.finished, r.completion_time,
                       r.turnaround, r.waiting, r.all_done);
    endfunction

    function void check_report(pps_pkg::out_item_t got);
      pps_pkg::out_item_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: report with nothing pending: %s", $time, show(got));
        return;
      end
      want = pending_reports.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: report mismatch", $time);
        $display("  expected %s", show(want));
        $display("  actual   %s", show(got));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  pps_in_if  in_chan ();
  pps_out_if out_chan ();
  pps_cfg_if cfg_chan ();

  preemptive_priority_scheduler i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  sched_tracker sb = new();

  // idle percentages for sender and receiver, switched by stimulus phase
  int send_idle_pct = 33;
  int recv_idle_pct = 70;
  int items_sent    = 0;
  int cfg_writes    = 0;
  int directed_n    = 0;
  int quiet_cycles  = 0;

  always #10 clk = ~clk;

  // Receiver: ready changes on the falling edge only.
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result monitor, sampled on the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      sb.check_report(out_chan.data);
    end
  end

  // Watchdog: any transaction on any channel resets the count.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, no transaction for %0d cycles",
               $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input transaction, with random sender gaps ahead of it.
  // valid stays high into the next item when no gap is drawn.
  task automatic send_item(input pps_pkg::in_item_t item);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= item;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_request(item);
    items_sent++;
  endtask

  task automatic send_load(input logic [3:0] slot, input logic [15:0] arr,
                           input logic [15:0] bur, input logic [7:0] pr);
    pps_pkg::in_item_t item;
    item.cmd          = pps_pkg::CMD_LOAD;
    item.slot         = slot;
    item.arrival      = arr;
    item.burst        = bur;
    item.priority_req = pr;
    send_item(item);
  endtask

  // Tick; the unused payload fields carry junk on purpose.
  task automatic send_tick();
    pps_pkg::in_item_t item;
    item     = pps_pkg::in_item_t'({$urandom, $urandom});
    item.cmd = pps_pkg::CMD_TICK;
    send_item(item);
  endtask

  // Load with small arrival, burst and prio most of the time so the
  // schedule actually plays out; sometimes full-range or zero-burst.
  task automatic send_random_load(input logic [3:0] slot, output int bur_out);
    logic [15:0] arr;
    logic [15:0] bur;
    logic [7:0]  pr;
    int          pick;
    arr  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    pick = $urandom_range(29);
    if (pick == 0) begin
      bur = '0;
    end else if (pick < 4) begin
      bur = 16'($urandom_range(1, 65535));
    end else begin
      bur = 16'($urandom_range(1, 6));
    end
    pr = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    send_load(slot, arr, bur, pr);
    bur_out = bur;
  endtask

  // Drop valid and let every pending report come back; the block is idle then.
  task automatic wait_quiet();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
  endtask

  // Register write, only called once the block is idle.
  task automatic write_count(input logic [4:0] value);
    wait_quiet();
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= value;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    sb.set_count(value);
    cfg_writes++;
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // One random phase: new count, fill the active slots, then tick for the total
  // burst plus up to 8, at most 48 ticks. A few phases are pure noise instead.
  task automatic run_scenario();
    logic [4:0] cnt;
    int         pick;
    int         n_eff;
    int         work;
    int         bur;
    int         ticks;
    pick = $urandom_range(99);
    if (pick < 5) begin
      cnt = 5'd0;
    end else if (pick < 12) begin
      cnt = 5'd16;
    end else if (pick < 16) begin
      cnt = 5'($urandom_range(17, 31));
    end else if (pick < 50) begin
      cnt = 5'($urandom_range(1, 4));
    end else begin
      cnt = 5'($urandom_range(1, 10));
    end
    write_count(cnt);
    n_eff = (cnt > pps_pkg::MAX_PROCS) ? pps_pkg::MAX_PROCS : cnt;
    work  = 0;
    if ($urandom_range(9) == 0) begin
      // noise: random mix of loads and ticks
      repeat ($urandom_range(5, 20)) begin
        if ($urandom_range(1) == 1) begin
          send_tick();
        end else begin
          send_random_load(4'($urandom), bur);
        end
      end
    end else begin
      for (int s = 0; s < n_eff; s++) begin
        send_random_load(4'(s), bur);
        work += bur;
      end
      // occasionally park work in an inactive slot
      if (n_eff < pps_pkg::MAX_PROCS && $urandom_range(3) == 0) begin
        send_random_load(4'($urandom_range(n_eff, pps_pkg::MAX_PROCS - 1)), bur);
      end
      ticks = work + $urandom_range(0, 8);
      if (ticks > 48) ticks = 48;
      repeat (ticks) begin
        // a stray load mid-run restarts the clock
        if ($urandom_range(24) == 0) begin
          send_random_load(4'($urandom), bur);
        end
        send_tick();
      end
    end
  endtask

  initial begin
    // everything known from time zero, reset held low
    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.data    = '0;
    cfg_chan.valid  = 1'b0;
    cfg_chan.data   = '0;
    out_chan.ready  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // no active slots: ticks are idle and report all done
    write_count(5'd0);
    send_tick();
    send_tick();

    // four slots: preemption by a better prio, a tie broken by slot order,
    // a zero-burst slot that never runs, then idle ticks at the end
    write_count(5'd4);
    send_load(4'd0, 16'd0, 16'd3, 8'd10);
    send_load(4'd1, 16'd1, 16'd1, 8'd5);
    send_load(4'd2, 16'd2, 16'd2, 8'd10);
    send_load(4'd3, 16'd0, 16'd0, 8'd0);
    repeat (8) send_tick();

    // full table, field extremes
    write_count(5'd16);
    send_load(4'd15, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_load(4'd14, 16'd0, 16'hFFFF, 8'd0);
    repeat (2) send_tick();

    // count above the table size saturates
    write_count(5'd31);
    repeat (2) send_tick();
    directed_n = items_sent;

    // ---- random part, idling pattern by phase ----
    while (items_sent - directed_n < RANDOM_ITEMS) begin
      if (items_sent - directed_n < RANDOM_ITEMS / 3) begin
        send_idle_pct = 33;
        recv_idle_pct = 70;
      end else if (items_sent - directed_n < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_scenario();
    end

    // drain, then watch a little longer for stray reports
    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_reports.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d reports never arrived", $time, sb.pending_reports.size());
    end

    $display("Ran %0d transactions (%0d directed) over %0d count settings:",
             items_sent, directed_n, cfg_writes);
    $display("  %0d loads, %0d run ticks with %0d completions, %0d idle ticks",
             sb.n_loads, sb.n_runs, sb.n_done, sb.n_idle);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pps_pkg.sv
rtl/core/pps_if.sv
rtl/core/pps_alu.sv
rtl/core/pps_slot_file.sv
rtl/core/preemptive_priority_scheduler.sv
rtl/core/pps_checker.sv
dv/tb_top.sv
